@@ design/ihp_pkg.sv @@
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants of the IP transport header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ihp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
	localparam logic [7:0] PROTO_ICMP    = 8'd1;
	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] PROTO_UDP     = 8'd17;
	localparam logic [7:0] PROTO_ROUTING = 8'd43;
	localparam logic [7:0] PROTO_FRAG    = 8'd44;
	localparam logic [7:0] PROTO_AH      = 8'd51;
	localparam logic [7:0] PROTO_ICMPV6  = 8'd58;
	localparam logic [7:0] PROTO_DSTOPTS = 8'd60;

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_IP_SHORT   = 3'd1;
	localparam logic [2:0] ST_NOT_IP     = 3'd2;
	localparam logic [2:0] ST_CHAIN_BAD  = 3'd3;
	localparam logic [2:0] ST_L4_SHORT   = 3'd4;

	localparam logic [1:0] TCP_UNKNOWN     = 2'd0;
	localparam logic [1:0] TCP_OPEN        = 2'd1;
	localparam logic [1:0] TCP_ESTABLISHED = 2'd2;
	localparam logic [1:0] TCP_CLOSE       = 2'd3;

	// Per-packet summary handed from the front to the back.
	typedef struct packed {
		logic [15:0] pkt_len;
		logic [3:0]  ver;
		logic [2:0]  err;
		logic        chain_done;
		logic [7:0]  proto;
		logic [15:0] hdr_start;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [39:0] l4;
	} rec_t;

	function automatic logic is_ext(input logic [7:0] p);
		return (p == PROTO_HOPOPT) || (p == PROTO_ROUTING) || (p == PROTO_FRAG) ||
			(p == PROTO_AH) || (p == PROTO_DSTOPTS);
	endfunction

endpackage

`default_nettype wire

@@ design/ihp_front.sv @@
// ----------------------------------------------------------------------------
// ihp_front
// Per-byte header walk; emits one packet summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ihp_front #(
	parameter int unsigned MAX_EXT_HEADERS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    pkt_byte,
	input  wire logic          last_byte,
	output ihp_pkg::rec_t      rec,
	output logic               rec_push
);

	localparam int unsigned ExtW = $clog2(MAX_EXT_HEADERS + 1);
	localparam logic [ExtW-1:0] ExtMax = ExtW'(MAX_EXT_HEADERS);

	logic [15:0]     idx_q, n_idx;
	logic [3:0]      ver_q, n_ver;
	logic [7:0]      np_q, n_np;
	logic [15:0]     hs_q, n_hs;
	logic            cd_q, n_cd;
	logic [ExtW-1:0] ext_q, n_ext;
	logic [63:0]     src0_q, src1_q, dst0_q, dst1_q;
	logic [63:0]     n_src0, n_src1, n_dst0, n_dst1;
	logic [39:0]     l4_q, n_l4;
	logic [2:0]      err_q, n_err;

	logic            live;
	logic [11:0]     adv;
	logic [16:0]     ns;
	logic [15:0]     rel;

	always_comb begin
		n_idx = idx_q; n_ver = ver_q; n_np = np_q; n_hs = hs_q; n_cd = cd_q;
		n_ext = ext_q; n_src0 = src0_q; n_src1 = src1_q; n_dst0 = dst0_q;
		n_dst1 = dst1_q; n_l4 = l4_q; n_err = err_q;
		adv = 12'd0; ns = 17'd0; rel = 16'd0;
		live = (idx_q != 16'hFFFF);
		if (live) begin
			n_idx = idx_q + 16'd1;
			if (idx_q == 16'd0) begin
				n_ver = pkt_byte[7:4];
				if (pkt_byte[7:4] == ihp_pkg::VER_IPV4) begin
					if (pkt_byte[3:0] < 4'd5) begin
						n_err = ihp_pkg::ST_IP_SHORT;
					end else begin
						n_hs = {10'd0, pkt_byte[3:0], 2'b00};
						n_cd = 1'b1;
					end
				end else if (pkt_byte[7:4] == ihp_pkg::VER_IPV6) begin
					n_hs = 16'd40;
				end
			end
			if (n_ver == ihp_pkg::VER_IPV4 && n_err == ihp_pkg::ST_OK) begin
				if (idx_q == 16'd9) n_np = pkt_byte;
				else if (idx_q >= 16'd12 && idx_q <= 16'd15)
					n_src1 = {32'd0, src1_q[23:0], pkt_byte};
				else if (idx_q >= 16'd16 && idx_q <= 16'd19)
					n_dst1 = {32'd0, dst1_q[23:0], pkt_byte};
			end else if (n_ver == ihp_pkg::VER_IPV6) begin
				if (idx_q == 16'd6) n_np = pkt_byte;
				else if (idx_q >= 16'd8 && idx_q <= 16'd15)
					n_src0 = {src0_q[55:0], pkt_byte};
				else if (idx_q >= 16'd16 && idx_q <= 16'd23)
					n_src1 = {src1_q[55:0], pkt_byte};
				else if (idx_q >= 16'd24 && idx_q <= 16'd31)
					n_dst0 = {dst0_q[55:0], pkt_byte};
				else if (idx_q >= 16'd32 && idx_q <= 16'd39)
					n_dst1 = {dst1_q[55:0], pkt_byte};
				// extension walk: next-header byte then length byte
				if (idx_q >= 16'd40 && !cd_q) begin
					if (np_q == ihp_pkg::PROTO_FRAG) adv = 12'd8;
					else if (np_q == ihp_pkg::PROTO_AH)
						adv = {2'b00, pkt_byte, 2'b00} + 12'd8;
					else adv = {1'b0, pkt_byte, 3'b000} + 12'd8;
					ns = {1'b0, hs_q} + {5'd0, adv};
					if (idx_q == hs_q) begin
						if (ihp_pkg::is_ext(np_q)) begin
							if (ext_q >= ExtMax) begin
								n_err = ihp_pkg::ST_CHAIN_BAD;
								n_cd  = 1'b1;
							end else begin
								n_l4 = {32'd0, pkt_byte};
							end
						end else begin
							n_cd = 1'b1;
							n_l4 = 40'd0;
						end
					end else if ({1'b0, idx_q} == {1'b0, hs_q} + 17'd1) begin
						if (ns[16]) begin
							n_err = ihp_pkg::ST_CHAIN_BAD;
							n_cd  = 1'b1;
						end else begin
							n_hs  = ns[15:0];
							n_np  = l4_q[7:0];
							n_ext = ext_q + ExtW'(1);
							n_l4  = 40'd0;
						end
					end
				end
			end
			// capture transport header bytes
			if (n_cd && n_err == ihp_pkg::ST_OK && idx_q >= n_hs) begin
				rel = idx_q - n_hs;
				if (rel < 16'd4) begin
					case (rel[1:0])
						2'd0: n_l4[39:32] = pkt_byte;
						2'd1: n_l4[31:24] = pkt_byte;
						2'd2: n_l4[23:16] = pkt_byte;
						default: n_l4[15:8] = pkt_byte;
					endcase
				end else if (rel == 16'd13) begin
					n_l4[7:0] = pkt_byte;
				end
			end
		end
	end

	assign rec_push = take && last_byte;

	always_comb begin
		rec.pkt_len    = live ? idx_q + 16'd1 : 16'hFFFF;
		rec.ver        = n_ver;
		rec.err        = n_err;
		rec.chain_done = n_cd;
		rec.proto      = n_np;
		rec.hdr_start  = n_hs;
		rec.src_hi     = n_src0;
		rec.src_lo     = n_src1;
		rec.dst_hi     = n_dst0;
		rec.dst_lo     = n_dst1;
		rec.l4         = n_l4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; ver_q <= '0; np_q <= '0; hs_q <= '0; cd_q <= 1'b0;
			ext_q <= '0; src0_q <= '0; src1_q <= '0; dst0_q <= '0; dst1_q <= '0;
			l4_q <= '0; err_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				// drop all packet state for the next packet
				idx_q <= '0; ver_q <= '0; np_q <= '0; hs_q <= '0; cd_q <= 1'b0;
				ext_q <= '0; src0_q <= '0; src1_q <= '0; dst0_q <= '0; dst1_q <= '0;
				l4_q <= '0; err_q <= '0;
			end else begin
				idx_q <= n_idx; ver_q <= n_ver; np_q <= n_np; hs_q <= n_hs;
				cd_q <= n_cd; ext_q <= n_ext; src0_q <= n_src0; src1_q <= n_src1;
				dst0_q <= n_dst0; dst1_q <= n_dst1; l4_q <= n_l4; err_q <= n_err;
			end
		end
	end

	a_ext_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ext_q <= ExtMax) else $error("extension count beyond limit");
	a_err_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ihp_pkg::ST_OK && !(take && last_byte)) |=> (err_q == $past(err_q)))
		else $error("early status changed mid packet");

endmodule

`default_nettype wire

@@ design/ihp_queue.sv @@
// ----------------------------------------------------------------------------
// ihp_queue
// Short queue of packet summaries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ihp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire ihp_pkg::rec_t wr_data,
	input  wire logic          rd_en,
	output logic               full,
	output logic               avail,
	output ihp_pkg::rec_t      rd_data
);

	localparam int unsigned PtrW = (ihp_pkg::QUEUE_DEPTH > 1) ?
		$clog2(ihp_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(ihp_pkg::QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] Depth = CntW'(ihp_pkg::QUEUE_DEPTH);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(ihp_pkg::QUEUE_DEPTH - 1);

	ihp_pkg::rec_t   mem_q [ihp_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr, do_rd;

	assign full    = (cnt_q == Depth);
	assign avail   = (cnt_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && avail;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == LastPtr) ? '0 : wp_q + PtrW'(1);
			if (do_rd) rp_q <= (rp_q == LastPtr) ? '0 : rp_q + PtrW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + CntW'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - CntW'(1);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Depth) else $error("queue count overflow");
	a_no_lost_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && full && !rd_en) |=> full) else $error("queue lost fill level");

endmodule

`default_nettype wire

@@ design/ihp_back.sv @@
// ----------------------------------------------------------------------------
// ihp_back
// Turns a packet summary into the result item and holds it for the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module ihp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rec_avail,
	input  wire ihp_pkg::rec_t rec,
	output logic               rec_pop,
	input  wire logic          pop,
	output logic               empty,
	output logic [63:0]        src_addr_hi,
	output logic [63:0]        src_addr_lo,
	output logic [63:0]        dst_addr_hi,
	output logic [63:0]        dst_addr_lo,
	output logic [7:0]         transport_proto,
	output logic [15:0]        transport_offset,
	output logic [15:0]        src_port,
	output logic [15:0]        dst_port,
	output logic [7:0]         icmp_type,
	output logic [7:0]         icmp_code,
	output logic [1:0]         tcp_state,
	output logic [2:0]         parse_status
);

	logic        valid_q;
	logic [63:0] sh, sl, dh, dl;
	logic [7:0]  pr, it, ic;
	logic [15:0] off, sp, dp;
	logic [1:0]  ts;
	logic [2:0]  st;
	logic [16:0] need, reach;
	logic        v4, v6;

	always_comb begin
		sh = '0; sl = '0; dh = '0; dl = '0; pr = '0; off = '0; sp = '0; dp = '0;
		it = '0; ic = '0; ts = ihp_pkg::TCP_UNKNOWN; st = ihp_pkg::ST_OK;
		need = '0; reach = '0;
		v4 = (rec.ver == ihp_pkg::VER_IPV4);
		v6 = (rec.ver == ihp_pkg::VER_IPV6);
		if (rec.pkt_len < 16'd20) st = ihp_pkg::ST_IP_SHORT;
		else if (!v4 && !v6) st = ihp_pkg::ST_NOT_IP;
		else if (v4 && rec.err == ihp_pkg::ST_IP_SHORT) st = ihp_pkg::ST_IP_SHORT;
		else if (v6 && rec.pkt_len < 16'd40) st = ihp_pkg::ST_IP_SHORT;
		else begin
			if (v4) begin
				sl = {32'h0000FFFF, rec.src_lo[31:0]};
				dl = {32'h0000FFFF, rec.dst_lo[31:0]};
			end else begin
				sh = rec.src_hi; sl = rec.src_lo; dh = rec.dst_hi; dl = rec.dst_lo;
			end
			pr = rec.proto;
			if (rec.err == ihp_pkg::ST_CHAIN_BAD ||
				(v6 && !rec.chain_done && ihp_pkg::is_ext(pr))) begin
				st = ihp_pkg::ST_CHAIN_BAD;
			end else begin
				off = rec.hdr_start;
				if (pr == ihp_pkg::PROTO_TCP) need = 17'd20;
				else if (pr == ihp_pkg::PROTO_UDP || pr == ihp_pkg::PROTO_ICMP ||
					pr == ihp_pkg::PROTO_ICMPV6) need = 17'd8;
				reach = {1'b0, off} + need;
				if (need != '0 && {1'b0, rec.pkt_len} < reach) begin
					st = ihp_pkg::ST_L4_SHORT;
				end else if (pr == ihp_pkg::PROTO_TCP || pr == ihp_pkg::PROTO_UDP) begin
					sp = rec.l4[39:24];
					dp = rec.l4[23:8];
					if (pr == ihp_pkg::PROTO_TCP) begin
						if (rec.l4[0] || rec.l4[2]) ts = ihp_pkg::TCP_CLOSE;
						else if (rec.l4[1])
							ts = rec.l4[4] ? ihp_pkg::TCP_ESTABLISHED : ihp_pkg::TCP_OPEN;
					end
				end else if (pr == ihp_pkg::PROTO_ICMP || pr == ihp_pkg::PROTO_ICMPV6) begin
					it = rec.l4[39:32];
					ic = rec.l4[31:24];
				end
			end
		end
	end

	// Load a new result when the holding register is free or being drained.
	assign rec_pop = rec_avail && (!valid_q || pop);
	assign empty   = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			src_addr_hi <= sh; src_addr_lo <= sl; dst_addr_hi <= dh; dst_addr_lo <= dl;
			transport_proto <= pr; transport_offset <= off; src_port <= sp;
			dst_port <= dp; icmp_type <= it; icmp_code <= ic; tcp_state <= ts;
			parse_status <= st;
		end
	end

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (parse_status <= ihp_pkg::ST_L4_SHORT)) else $error("bad status");
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(parse_status)))
		else $error("waiting result disturbed");

endmodule

`default_nettype wire

@@ design/ip_transport_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ip_transport_header_parser_unit
// IPv4/IPv6 five-tuple parser: byte stream in, one summary item per packet out.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | push / full       | pkt_byte, last_byte (one item per byte)
//  result   | empty / pop       | addresses, proto, offset, ports, icmp,
//           |                   | tcp_state, parse_status
//
//  One byte is taken every cycle while full is low; the front's per-byte walk
//  is a single register stage.
//  A result reaches the ports in order: the edge that takes the last byte writes
//  the summary queue, then the result register loads it once free or being popped.
//  full rises only while the summary queue holds two packets, i.e. when
//  results are not popped and two more packets have finished.
//  arst_n clears all packet state, the queue and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_transport_header_parser_unit #(
	parameter int unsigned MAX_EXT_HEADERS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  pkt_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      src_addr_hi,
	output logic [63:0]      src_addr_lo,
	output logic [63:0]      dst_addr_hi,
	output logic [63:0]      dst_addr_lo,
	output logic [7:0]       transport_proto,
	output logic [15:0]      transport_offset,
	output logic [15:0]      src_port,
	output logic [15:0]      dst_port,
	output logic [7:0]       icmp_type,
	output logic [7:0]       icmp_code,
	output logic [1:0]       tcp_state,
	output logic [2:0]       parse_status
);

	ihp_pkg::rec_t f_rec, q_rec;
	logic          f_push, q_avail, q_pop, take;

	// Accept a byte only while the summary queue can take a finished packet.
	assign take = push && !full;

	ihp_front #(.MAX_EXT_HEADERS(MAX_EXT_HEADERS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .pkt_byte(pkt_byte),
		.last_byte(last_byte), .rec(f_rec), .rec_push(f_push)
	);

	ihp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(f_push), .wr_data(f_rec),
		.rd_en(q_pop), .full(full), .avail(q_avail), .rd_data(q_rec)
	);

	ihp_back u_back (
		.clk(clk), .arst_n(arst_n), .rec_avail(q_avail), .rec(q_rec),
		.rec_pop(q_pop), .pop(pop), .empty(empty),
		.src_addr_hi(src_addr_hi), .src_addr_lo(src_addr_lo),
		.dst_addr_hi(dst_addr_hi), .dst_addr_lo(dst_addr_lo),
		.transport_proto(transport_proto), .transport_offset(transport_offset),
		.src_port(src_port), .dst_port(dst_port), .icmp_type(icmp_type),
		.icmp_code(icmp_code), .tcp_state(tcp_state), .parse_status(parse_status)
	);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(q_avail && empty) |=> !empty) else $error("queued summary not loaded");

endmodule

`default_nettype wire
